// ===== design/ptps_pkg.sv =====
// Package for the pan/tilt PID servo ramp core: widths, constants, register
// indexes and the structs shared between the lanes, the ramp and the top level.
// No dependencies.
`default_nettype none

package ptps_pkg;

    localparam int ERR_W  = 10;
    localparam int GAIN_W = 16;
    localparam int INT_W  = 24;
    localparam int CMP_W  = 8;
    localparam int IDX_W  = 3;

    localparam logic [CMP_W-1:0] CMP_MAX = 8'd165;
    localparam logic [CMP_W-1:0] CMP_MIN = 8'd135;
    localparam logic [CMP_W-1:0] CMP_MID = 8'd150;

    localparam logic signed [INT_W-1:0] INT_MAXV = 24'sh7FFFFF;
    localparam logic signed [INT_W-1:0] INT_MINV = 24'sh800000;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_PAN_KP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PAN_KI  = 3'd1;
    localparam logic [IDX_W-1:0] REG_PAN_KD  = 3'd2;
    localparam logic [IDX_W-1:0] REG_TILT_KP = 3'd3;
    localparam logic [IDX_W-1:0] REG_TILT_KI = 3'd4;
    localparam logic [IDX_W-1:0] REG_TILT_KD = 3'd5;

    localparam logic [GAIN_W-1:0] PAN_KP_RST  = 16'd13107;
    localparam logic [GAIN_W-1:0] PAN_KI_RST  = 16'd1966;
    localparam logic [GAIN_W-1:0] PAN_KD_RST  = 16'd0;
    localparam logic [GAIN_W-1:0] TILT_KP_RST = 16'd12452;
    localparam logic [GAIN_W-1:0] TILT_KI_RST = 16'd655;
    localparam logic [GAIN_W-1:0] TILT_KD_RST = 16'd0;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gain_t;

    typedef struct packed {
        logic             done;
        logic [CMP_W-1:0] target;
    } lane_stat_t;

endpackage

`default_nettype wire

// ===== design/ptps_if.sv =====
// Valid/ready channel interfaces of the pan/tilt PID servo ramp core:
// the camera error channel and the servo compare channel. Depends on ptps_pkg.
`default_nettype none

interface ptps_err_if
    import ptps_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] cam_x_error;
    logic signed [ERR_W-1:0] cam_y_error;

    modport source (output valid, output cam_x_error, output cam_y_error, input ready);
    modport sink   (input valid, input cam_x_error, input cam_y_error, output ready);
endinterface

interface ptps_servo_if
    import ptps_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMP_W-1:0] pan_compare;
    logic [CMP_W-1:0] tilt_compare;
    logic             last_step;

    modport source (output valid, output pan_compare, output tilt_compare,
                    output last_step, input ready);
    modport sink   (input valid, input pan_compare, input tilt_compare,
                    input last_step, output ready);
endinterface

`default_nettype wire

// ===== design/ptps_pid_lane.sv =====
// One PID lane: saturating integral, derivative, three gain products,
// truncation toward zero and clamped retarget. Depends on ptps_pkg.
`default_nettype none

module ptps_pid_lane
    import ptps_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [ERR_W-1:0] err,
    input  wire gain_t                   gains,
    output      lane_stat_t              stat
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MUL  = 3'd1;
    localparam logic [2:0] PH_SUM  = 3'd2;
    localparam logic [2:0] PH_CORR = 3'd3;
    localparam logic [2:0] PH_TGT  = 3'd4;

    localparam int P_W   = GAIN_W + 1 + ERR_W;
    localparam int I_W   = GAIN_W + 1 + INT_W;
    localparam int D_W   = GAIN_W + 1 + ERR_W + 1;
    localparam int ACC_W = I_W + 2;
    localparam int COR_W = ACC_W - 16;
    localparam int T_W   = COR_W + 1;

    logic [2:0]                phase_reg, phase_next;
    logic signed [INT_W-1:0]   integral_reg, integral_next;
    logic signed [ERR_W-1:0]   prev_reg;
    logic [CMP_W-1:0]          target_reg, target_next;
    logic                      done_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [ERR_W:0]     diff_reg;
    logic signed [P_W-1:0]     p_reg, p_next;
    logic signed [I_W-1:0]     i_reg, i_next;
    logic signed [D_W-1:0]     d_reg, d_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next, acc_adj;
    logic signed [COR_W-1:0]   corr_reg;
    logic signed [INT_W:0]     isum;
    logic signed [GAIN_W:0]    kp_s, ki_s, kd_s;
    logic signed [T_W-1:0]     tdiff;

    assign kp_s = signed'({1'b0, gains.kp});
    assign ki_s = signed'({1'b0, gains.ki});
    assign kd_s = signed'({1'b0, gains.kd});

    always_comb
    begin
        isum = (INT_W+1)'(integral_reg) + (INT_W+1)'(err);
        if (isum > (INT_W+1)'(INT_MAXV))
        begin
            integral_next = INT_MAXV;
        end
        else if (isum < (INT_W+1)'(INT_MINV))
        begin
            integral_next = INT_MINV;
        end
        else
        begin
            integral_next = isum[INT_W-1:0];
        end
    end

    assign p_next   = kp_s * e_reg;
    assign i_next   = ki_s * integral_reg;
    assign d_next   = kd_s * diff_reg;
    assign acc_next = ACC_W'(p_reg) + ACC_W'(i_reg) + ACC_W'(d_reg);

    // round toward zero: bias negative sums before the arithmetic shift
    assign acc_adj  = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));

    // compare signed so a target pulled below zero clamps to the low limit
    always_comb
    begin
        tdiff = signed'(T_W'(target_reg)) - T_W'(corr_reg);
        if (tdiff > signed'(T_W'(CMP_MAX)))
        begin
            target_next = CMP_MAX;
        end
        else if (tdiff < signed'(T_W'(CMP_MIN)))
        begin
            target_next = CMP_MIN;
        end
        else
        begin
            target_next = tdiff[CMP_W-1:0];
        end
    end

    always_comb
    begin
        case (phase_reg)
            PH_IDLE: phase_next = start ? PH_MUL : PH_IDLE;
            PH_MUL:  phase_next = PH_SUM;
            PH_SUM:  phase_next = PH_CORR;
            PH_CORR: phase_next = PH_TGT;
            PH_TGT:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            integral_reg <= '0;
            prev_reg     <= '0;
            target_reg   <= CMP_MID;
            done_reg     <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_TGT);
            if (phase_reg == PH_IDLE && start)
            begin
                integral_reg <= integral_next;
                prev_reg     <= err;
            end
            if (phase_reg == PH_TGT)
            begin
                target_reg <= target_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            e_reg    <= err;
            diff_reg <= (ERR_W+1)'(err) - (ERR_W+1)'(prev_reg);
        end
        if (phase_reg == PH_MUL)
        begin
            p_reg <= p_next;
            i_reg <= i_next;
            d_reg <= d_next;
        end
        if (phase_reg == PH_SUM)
        begin
            acc_reg <= acc_next;
        end
        if (phase_reg == PH_CORR)
        begin
            corr_reg <= acc_adj[ACC_W-1:16];
        end
    end

    assign stat.done   = done_reg;
    assign stat.target = target_reg;

endmodule

`default_nettype wire

// ===== design/ptps_ramp.sv =====
// Merge stage: steps both current compare values toward the lane targets,
// one transaction per step, through an output register. Depends on ptps_pkg.
`default_nettype none

module ptps_ramp
    import ptps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lane_stat_t       pan_stat,
    input  wire lane_stat_t       tilt_stat,
    input  wire logic             out_ready,
    output      logic             out_valid,
    output      logic [CMP_W-1:0] pan_cmp,
    output      logic [CMP_W-1:0] tilt_cmp,
    output      logic             last,
    output      logic             done
);

    logic [CMP_W-1:0] pan_cur_reg, tilt_cur_reg;
    logic [CMP_W-1:0] pan_cur_next, tilt_cur_next;
    logic [CMP_W-1:0] pan_out_reg, tilt_out_reg;
    logic             last_reg, last_next;
    logic             valid_reg;
    logic             active_reg;
    logic             start, settled, load;

    assign start   = pan_stat.done & tilt_stat.done;
    assign settled = (pan_cur_reg == pan_stat.target) && (tilt_cur_reg == tilt_stat.target);
    assign load    = active_reg && (!valid_reg || out_ready);

    always_comb
    begin
        pan_cur_next = pan_cur_reg;
        if (pan_cur_reg < pan_stat.target)
        begin
            pan_cur_next = pan_cur_reg + 8'd1;
        end
        else if (pan_cur_reg > pan_stat.target)
        begin
            pan_cur_next = pan_cur_reg - 8'd1;
        end
        tilt_cur_next = tilt_cur_reg;
        if (tilt_cur_reg < tilt_stat.target)
        begin
            tilt_cur_next = tilt_cur_reg + 8'd1;
        end
        else if (tilt_cur_reg > tilt_stat.target)
        begin
            tilt_cur_next = tilt_cur_reg - 8'd1;
        end
        last_next = (pan_cur_next == pan_stat.target) && (tilt_cur_next == tilt_stat.target);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_cur_reg  <= CMP_MID;
            tilt_cur_reg <= CMP_MID;
            valid_reg    <= 1'b0;
            active_reg   <= 1'b0;
        end
        else
        begin
            if (start && !settled)
            begin
                active_reg <= 1'b1;
            end
            else if (load && last_next)
            begin
                active_reg <= 1'b0;
            end
            if (load)
            begin
                pan_cur_reg  <= pan_cur_next;
                tilt_cur_reg <= tilt_cur_next;
                valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pan_out_reg  <= pan_cur_next;
            tilt_out_reg <= tilt_cur_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign pan_cmp   = pan_out_reg;
    assign tilt_cmp  = tilt_out_reg;
    assign last      = last_reg;
    assign done      = (start && settled) || (load && last_next);

endmodule

`default_nettype wire

// ===== design/pan_tilt_pid_servo_ramp_core.sv =====
// Two-axis pan/tilt positional PID controller with ramped servo compare output.
// Depends on ptps_pkg, ptps_err_if/ptps_servo_if, ptps_pid_lane and ptps_ramp.
//
// Each transaction on error_ch carries camera x and y offsets. Two PID lanes
// run side by side: the y offset drives the pan lane and the x offset the tilt
// lane. Each lane saturates its integral at 24 bits signed, forms
// kp*e + ki*I + kd*(e - prev) with unsigned Q0.16 gains, truncates toward zero
// and subtracts the result from its target, clamped to 135..165. The ramp stage
// then steps both current compare values one count toward their targets per
// servo_ch transaction, flagging the final step with last_step; an item whose
// targets already match the currents yields no transaction. After acceptance
// the lanes work through integral, products, sum, rounding and retarget in
// turn, then the ramp emits one step per cycle while servo_ch is ready, up to
// 30 steps. error_ch is ready again once the last step sits in the output
// register, so the next item's PID work overlaps with a waiting final result.
// Gains are written through cfg_we/cfg_index/cfg_wdata; write them only while
// the block is idle. Writes to unknown indexes are dropped.
`default_nettype none

module pan_tilt_pid_servo_ramp_core
    import ptps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    ptps_err_if.sink               error_ch,
    ptps_servo_if.source           servo_ch,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [GAIN_W-1:0] cfg_wdata
);

    gain_t      pan_gain_reg, tilt_gain_reg;
    lane_stat_t pan_stat, tilt_stat;
    logic       busy_reg;
    logic       accept;
    logic       ramp_done;

    // hold new transactions off until the last step is in the output register
    assign error_ch.ready = !busy_reg;
    assign accept         = error_ch.valid && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (ramp_done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // gain registers; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_gain_reg.kp  <= PAN_KP_RST;
            pan_gain_reg.ki  <= PAN_KI_RST;
            pan_gain_reg.kd  <= PAN_KD_RST;
            tilt_gain_reg.kp <= TILT_KP_RST;
            tilt_gain_reg.ki <= TILT_KI_RST;
            tilt_gain_reg.kd <= TILT_KD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PAN_KP:  pan_gain_reg.kp  <= cfg_wdata;
                REG_PAN_KI:  pan_gain_reg.ki  <= cfg_wdata;
                REG_PAN_KD:  pan_gain_reg.kd  <= cfg_wdata;
                REG_TILT_KP: tilt_gain_reg.kp <= cfg_wdata;
                REG_TILT_KI: tilt_gain_reg.ki <= cfg_wdata;
                REG_TILT_KD: tilt_gain_reg.kd <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // pan lane follows the y offset, tilt lane the x offset
    ptps_pid_lane u_pan_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .err   (error_ch.cam_y_error),
        .gains (pan_gain_reg),
        .stat  (pan_stat)
    );

    ptps_pid_lane u_tilt_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .err   (error_ch.cam_x_error),
        .gains (tilt_gain_reg),
        .stat  (tilt_stat)
    );

    ptps_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pan_stat  (pan_stat),
        .tilt_stat (tilt_stat),
        .out_ready (servo_ch.ready),
        .out_valid (servo_ch.valid),
        .pan_cmp   (servo_ch.pan_compare),
        .tilt_cmp  (servo_ch.tilt_compare),
        .last      (servo_ch.last_step),
        .done      (ramp_done)
    );

endmodule

`default_nettype wire

// ===== test/ptps_servo_checker.sv =====
// Scoreboard for the pan/tilt PID servo ramp core: watches the gain write port and
// both channels, predicts every servo step, and compares in order.
// Depends on ptps_pkg and the ptps_err_if / ptps_servo_if interfaces.
module ptps_servo_checker
    import ptps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ptps_err_if               err_mon,
    ptps_servo_if             servo_mon,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [GAIN_W-1:0] cfg_wdata,
    output int                mismatches,
    output int                steps_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANE_PAN  = 0;
    localparam int LANE_TILT = 1;
    localparam int MAX_STEPS = 30;
    localparam int PRINT_CAP = 60;

    typedef struct {
        gain_t                   gain;
        logic signed [INT_W-1:0] integral;
        logic signed [ERR_W-1:0] prev;
        logic [CMP_W-1:0]        target;
        logic [CMP_W-1:0]        current;
    } lane_state_t;

    typedef struct packed {
        logic [CMP_W-1:0] pan;
        logic [CMP_W-1:0] tilt;
        logic             last;
    } servo_step_t;

    lane_state_t lanes [2];
    servo_step_t steps_due [$];

    task automatic report_mismatch(input string msg);
        // cap the printout, keep counting
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // One PID update: saturate the integral, form the Q.16 sum, truncate toward
    // zero and pull the clamped target by the correction.
    function automatic void advance_lane(input int i, input logic signed [ERR_W-1:0] e);
        longint sum;
        longint acc;
        longint corr;
        longint tgt;
        sum = longint'(lanes[i].integral) + longint'(e);
        if (sum > longint'(INT_MAXV))
            sum = longint'(INT_MAXV);
        if (sum < longint'(INT_MINV))
            sum = longint'(INT_MINV);
        lanes[i].integral = sum[INT_W-1:0];
        acc = longint'(lanes[i].gain.kp) * longint'(e)
            + longint'(lanes[i].gain.ki) * longint'(lanes[i].integral)
            + longint'(lanes[i].gain.kd) * (longint'(e) - longint'(lanes[i].prev));
        lanes[i].prev = e;
        corr = (acc < 0) ? -((-acc) >>> 16) : (acc >>> 16);
        tgt = longint'(lanes[i].target) - corr;
        if (tgt > longint'(CMP_MAX))
            tgt = longint'(CMP_MAX);
        if (tgt < longint'(CMP_MIN))
            tgt = longint'(CMP_MIN);
        lanes[i].target = tgt[CMP_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        servo_step_t step;
        servo_step_t want;
        int          n;
        if (!rst_n)
        begin
            lanes[LANE_PAN].gain  = '{PAN_KP_RST, PAN_KI_RST, PAN_KD_RST};
            lanes[LANE_TILT].gain = '{TILT_KP_RST, TILT_KI_RST, TILT_KD_RST};
            for (int i = 0; i < 2; i++)
            begin
                lanes[i].integral = '0;
                lanes[i].prev     = '0;
                lanes[i].target   = CMP_MID;
                lanes[i].current  = CMP_MID;
            end
            steps_due.delete();
            mismatches    = 0;
            steps_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PAN_KP:  lanes[LANE_PAN].gain.kp  = cfg_wdata;
                    REG_PAN_KI:  lanes[LANE_PAN].gain.ki  = cfg_wdata;
                    REG_PAN_KD:  lanes[LANE_PAN].gain.kd  = cfg_wdata;
                    REG_TILT_KP: lanes[LANE_TILT].gain.kp = cfg_wdata;
                    REG_TILT_KI: lanes[LANE_TILT].gain.ki = cfg_wdata;
                    REG_TILT_KD: lanes[LANE_TILT].gain.kd = cfg_wdata;
                    default: ;
                endcase
            end

            if (err_mon.valid && err_mon.ready)
            begin
                // y offset steers pan, x offset steers tilt
                advance_lane(LANE_PAN, err_mon.cam_y_error);
                advance_lane(LANE_TILT, err_mon.cam_x_error);
                n = 0;
                while ((lanes[LANE_PAN].current != lanes[LANE_PAN].target ||
                        lanes[LANE_TILT].current != lanes[LANE_TILT].target) &&
                       n < MAX_STEPS)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        if (lanes[i].current < lanes[i].target)
                            lanes[i].current++;
                        else if (lanes[i].current > lanes[i].target)
                            lanes[i].current--;
                    end
                    step.pan  = lanes[LANE_PAN].current;
                    step.tilt = lanes[LANE_TILT].current;
                    step.last = (lanes[LANE_PAN].current == lanes[LANE_PAN].target) &&
                                (lanes[LANE_TILT].current == lanes[LANE_TILT].target);
                    steps_due.push_back(step);
                    n++;
                end
            end

            if (servo_mon.valid && servo_mon.ready)
            begin
                if (steps_due.size() == 0)
                    report_mismatch($sformatf("unexpected step pan=%0d tilt=%0d last=%0b",
                        servo_mon.pan_compare, servo_mon.tilt_compare,
                        servo_mon.last_step));
                else
                begin
                    want = steps_due.pop_front();
                    if (servo_mon.pan_compare !== want.pan)
                        report_mismatch($sformatf("pan_compare got %0d expected %0d",
                            servo_mon.pan_compare, want.pan));
                    if (servo_mon.tilt_compare !== want.tilt)
                        report_mismatch($sformatf("tilt_compare got %0d expected %0d",
                            servo_mon.tilt_compare, want.tilt));
                    if (servo_mon.last_step !== want.last)
                        report_mismatch($sformatf("last_step got %0b expected %0b",
                            servo_mon.last_step, want.last));
                end
            end
            steps_pending = steps_due.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Top of the pan/tilt PID servo ramp core testbench: clock, reset, camera error
// stimulus, gain writes and servo backpressure. Depends on ptps_pkg, the
// channel interfaces, the core and ptps_servo_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ptps_pkg::*;

    // Slowest legal run: ~384 items at up to 30 steps, each of which may wait out a
    // stall burst, plus sender gaps and settling; allow several times that run
    // before calling it hung.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // lanes keep working on an item after acceptance; an item with no steps may
    // still be in flight when the scoreboard is empty
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 44;

    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

    typedef enum int { G_MAX, G_ZERO, G_DERIV, G_WIDE, G_MILD } gain_style_t;
    typedef enum int { RX_OPEN, RX_RANDOM, RX_BURSTY } rx_mode_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [GAIN_W-1:0] cfg_wdata;
    int                mismatch_count;
    int                steps_pending;
    int                cycles = 0;

    // sender burst state
    int burst_left;
    bit steady;

    ptps_err_if   err_bus ();
    ptps_servo_if servo_bus ();

    pan_tilt_pid_servo_ramp_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .error_ch  (err_bus),
        .servo_ch  (servo_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ptps_servo_checker servo_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .err_mon       (err_bus),
        .servo_mon     (servo_bus),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatch_count),
        .steps_pending (steps_pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop if the run hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL pan_tilt_pid_servo_ramp_core");
            $finish;
        end
    end

    // Servo side backpressure: switch at random between always-ready, random ready (high two
    // times in three) and stall bursts, so stalls land on ramp steps at random.
    initial
    begin : servo_stall
        rx_mode_t mode;
        int       mode_left;
        int       hold;
        servo_bus.ready = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        hold      = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                servo_bus.ready <= 1'b0;
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(40, 200);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   servo_bus.ready <= 1'b1;
                    RX_RANDOM: servo_bus.ready <= ($urandom_range(0, 2) != 0);
                    default:
                    begin
                        if (hold > 0)
                        begin
                            servo_bus.ready <= 1'b0;
                            hold--;
                        end
                        else
                        begin
                            servo_bus.ready <= 1'b1;
                            if ($urandom_range(0, 5) == 0)
                                hold = $urandom_range(1, 12);
                        end
                    end
                endcase
            end
        end
    end

    // Offer one camera frame and hold it until the core takes it. Afterwards, unless
    // steady, either continue the burst or drop valid for a random gap, which may be empty.
    task automatic feed(input logic signed [ERR_W-1:0] x, input logic signed [ERR_W-1:0] y);
        int gap;
        err_bus.valid       <= 1'b1;
        err_bus.cam_x_error <= x;
        err_bus.cam_y_error <= y;
        do @(posedge clk); while (!err_bus.ready);
        if (steady)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 10);
            // now and then a long burst with no idle cycles at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 7);
            if (gap != 0)
            begin
                err_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid, wait until every predicted step has been seen, then give the
    // lanes time to finish a frame that produced no steps.
    task automatic settle();
        err_bus.valid <= 1'b0;
        do @(negedge clk); while (steps_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Load all six gains, then poke the two unused indexes; those writes must
    // not disturb any gain.
    task automatic load_gains(input gain_t pan, input gain_t tilt);
        write_reg(REG_PAN_KP, pan.kp);
        write_reg(REG_PAN_KI, pan.ki);
        write_reg(REG_PAN_KD, pan.kd);
        write_reg(REG_TILT_KP, tilt.kp);
        write_reg(REG_TILT_KI, tilt.ki);
        write_reg(REG_TILT_KD, tilt.kd);
        write_reg(REG_SPARE_A, GAIN_W'($urandom));
        write_reg(REG_SPARE_B, GAIN_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic gain_t pick_gains(input gain_style_t style);
        gain_t g;
        case (style)
            G_MAX:   g = '{{GAIN_W{1'b1}}, {GAIN_W{1'b1}}, {GAIN_W{1'b1}}};
            G_ZERO:  g = '0;
            G_DERIV: g = '{GAIN_W'($urandom_range(0, 8000)),
                           GAIN_W'($urandom_range(0, 400)), {GAIN_W{1'b1}}};
            G_WIDE:  g = '{GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom)};
            default: g = '{GAIN_W'($urandom_range(0, 20000)),
                           GAIN_W'($urandom_range(0, 3000)),
                           GAIN_W'($urandom_range(0, 20000))};
        endcase
        return g;
    endfunction

    // Half the picks are small offsets so the targets move inside the clamp window;
    // the other half are extremes and full-range values.
    function automatic logic signed [ERR_W-1:0] pick_error();
        case ($urandom_range(0, 9))
            0:       return ERR_MIN;
            1:       return ERR_MAX;
            2, 3, 4: return ERR_W'($urandom_range(0, 1023));
            default: return ERR_W'($urandom_range(0, 80) - 40);
        endcase
    endfunction

    initial
    begin : stimulus
        gain_t pan_g;
        gain_t tilt_g;
        err_bus.valid       = 1'b0;
        err_bus.cam_x_error = '0;
        err_bus.cam_y_error = '0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_wdata           = '0;
        burst_left          = 0;
        steady              = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset gains.
        feed(0, 0);                 // already on target: no steps
        feed(0, ERR_MAX);           // pan pinned at the low clamp, tilt holds
        feed(ERR_MIN, ERR_MIN);     // big negative correction, both to the top clamp
        feed(ERR_MAX, ERR_MIN);
        feed(-1, 1);                // small sums: truncation toward zero
        feed(1, -1);
        feed(0, 0);                 // zero error: only the integral term acts, and neither target moves
        feed(10'sh155, 10'sh2AA);   // alternating bit patterns
        feed(10'sh2AA, 10'sh155);
        feed(ERR_MIN, ERR_MAX);
        feed(5, -5);
        feed(0, 0);
        settle();

        // Randomized phases, each under its own gain set; extremes first.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    pan_g  = pick_gains(G_MAX);
                    tilt_g = pick_gains(G_MAX);
                end
                1:
                begin
                    pan_g  = pick_gains(G_ZERO);
                    tilt_g = pick_gains(G_ZERO);
                end
                2:
                begin
                    pan_g  = '{PAN_KP_RST, PAN_KI_RST, PAN_KD_RST};
                    tilt_g = '{TILT_KP_RST, TILT_KI_RST, TILT_KD_RST};
                end
                3:
                begin
                    pan_g  = pick_gains(G_DERIV);
                    tilt_g = pick_gains(G_MILD);
                end
                4:
                begin
                    pan_g  = pick_gains(G_WIDE);
                    tilt_g = pick_gains(G_DERIV);
                end
                default:
                begin
                    pan_g  = pick_gains(G_MILD);
                    tilt_g = pick_gains(G_MILD);
                end
            endcase
            load_gains(pan_g, tilt_g);
            repeat (PHASE_ITEMS) feed(pick_error(), pick_error());
            settle();
        end

        // Back-to-back frames with no sender gaps: swing hard one way, then
        // the other, to push the targets toward both clamps.
        steady = 1'b1;
        repeat (10) feed(ERR_MAX, ERR_MAX);
        repeat (10) feed(ERR_MIN, ERR_MIN);
        steady = 1'b0;
        settle();

        @(negedge clk);
        if (mismatch_count == 0 && steps_pending == 0)
            $display("PASS pan_tilt_pid_servo_ramp_core");
        else
            $display("FAIL pan_tilt_pid_servo_ramp_core");
        $finish;
    end

endmodule
